// ===== src/segtr_pkg.sv =====
// Shared types and constants for the range-add / range-sum core.
`timescale 1ns / 1ps
package segtr_pkg;

  // Fixed widths of the request and result fields
  localparam int CNT_W  = 11;
  localparam int VAL_W  = 32;
  localparam int SUM_W  = 64;
  localparam int ADDR_W = 3;

  // Request codes
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Register byte addresses
  localparam logic [ADDR_W-1:0] REG_ELEMENT_COUNT = 3'd0;

  // Which walk start point the datapath loads
  typedef enum logic [1:0] {
    PT_LEFT,       // update at l, +d
    PT_RIGHT_P1,   // update at r+1, -d
    PT_RIGHT,      // prefix up to r, added
    PT_LEFT_M1     // prefix up to l-1, subtracted
  } segtr_pt_t;

  // Controller to datapath commands
  typedef struct packed {
    logic      load;
    logic      set_pt;
    segtr_pt_t pt_sel;
    logic      mem_rd;
    logic      upd_wr;
    logic      qry_acc;
    logic      mul;
    logic      acc;
    logic      clr_wr;
  } segtr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic err;
    logic is_query;
    logic up_done;
    logic dn_done;
    logic clr_last;
  } segtr_sts_t;

endpackage

// ===== src/segtr_ctrl.sv =====
// Sequencer for request intake, tree walks, clearing and result handoff.
`timescale 1ns / 1ps
module segtr_ctrl
  import segtr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic       cfg_wr,
  input  logic       out_busy,
  input  segtr_sts_t sts,
  output logic       in_ready,
  output logic       out_load,
  output segtr_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_UP_RD, S_UP_WR,
    S_QY_RD, S_QY_ACC, S_MUL, S_ACC, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   phase_r, phase_nxt;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd       = '0;
    cmd.pt_sel = PT_LEFT;
    out_load  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        phase_nxt = 1'b0;
        if (sts.err) begin
          state_nxt = S_FIN;
        end else if (sts.is_query) begin
          cmd.set_pt = 1'b1;
          cmd.pt_sel = PT_RIGHT;
          state_nxt  = S_QY_RD;
        end else begin
          cmd.set_pt = 1'b1;
          cmd.pt_sel = PT_LEFT;
          state_nxt  = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (sts.up_done) begin
          if (!phase_r) begin
            cmd.set_pt = 1'b1;
            cmd.pt_sel = PT_RIGHT_P1;
            phase_nxt  = 1'b1;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          cmd.mem_rd = 1'b1;
          state_nxt  = S_UP_WR;
        end
      end
      S_UP_WR: begin
        cmd.upd_wr = 1'b1;
        state_nxt  = S_UP_RD;
      end
      S_QY_RD: begin
        if (sts.dn_done) begin
          state_nxt = S_MUL;
        end else begin
          cmd.mem_rd = 1'b1;
          state_nxt  = S_QY_ACC;
        end
      end
      S_QY_ACC: begin
        cmd.qry_acc = 1'b1;
        state_nxt   = S_QY_RD;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (!phase_r) begin
          cmd.set_pt = 1'b1;
          cmd.pt_sel = PT_LEFT_M1;
          phase_nxt  = 1'b1;
          state_nxt  = S_QY_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_busy) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  // State register; a count write restarts the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      phase_r <= 1'b0;
    end else if (cfg_wr) begin
      state_r <= S_CLEAR;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// ===== src/segtr_dpath.sv =====
// Datapath: two binary indexed tables in memory, walk index, multipliers, accumulator.
`timescale 1ns / 1ps
module segtr_dpath
  import segtr_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  segtr_cmd_t              cmd,
  input  logic                    cfg_wr,
  input  logic [CNT_W-1:0]        count,
  input  logic                    in_command,
  input  logic [CNT_W-1:0]        in_left_index,
  input  logic [CNT_W-1:0]        in_right_index,
  input  logic signed [VAL_W-1:0] in_add_value,
  output segtr_sts_t              sts,
  output logic signed [SUM_W-1:0] res_sum,
  output logic                    res_err
);

  localparam int AW    = $clog2(MAX_ELEMENTS + 1);
  localparam int DEPTH = 1 << AW;
  localparam int IW    = AW + 1;

  // Difference table and index-weighted difference table
  logic [SUM_W-1:0] b1_mem [DEPTH];
  logic [SUM_W-1:0] b2_mem [DEPTH];
  logic [SUM_W-1:0] q1_r, q2_r;

  logic             cmd_r, err_r, neg_r;
  logic [IW-1:0]    l_r, r_r, idx_r, w_r;
  logic [VAL_W-1:0] d_r;
  logic [SUM_W-1:0] d1_r, d2_r, s1_r, s2_r, prod_r, acc_r;
  logic [AW-1:0]    clr_addr_r;

  logic [IW-1:0]         pt, lowbit;
  logic                  pt_neg;
  logic signed [VAL_W+IW:0] dp;
  logic [SUM_W-1:0]      d_ext, dp_ext, diff;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [SUM_W-1:0]      wd1, wd2;

  // Start point of the next walk
  always_comb begin
    pt     = l_r;
    pt_neg = 1'b0;
    unique case (cmd.pt_sel)
      PT_LEFT:     begin pt = l_r;           pt_neg = 1'b0; end
      PT_RIGHT_P1: begin pt = r_r + 1'b1;    pt_neg = 1'b1; end
      PT_RIGHT:    begin pt = r_r;           pt_neg = 1'b0; end
      PT_LEFT_M1:  begin pt = l_r - 1'b1;    pt_neg = 1'b1; end
      default:     begin pt = l_r;           pt_neg = 1'b0; end
    endcase
  end

  // Point delta and index-weighted delta
  assign dp     = $signed(d_r) * $signed({1'b0, pt});
  assign d_ext  = SUM_W'($signed(d_r));
  assign dp_ext = SUM_W'(dp);
  assign lowbit = idx_r & (~idx_r + 1'b1);
  assign diff   = prod_r - s2_r;

  // Memory write port: clearing sweep or read-modify-write of a node
  assign we    = cmd.clr_wr | cmd.upd_wr;
  assign waddr = cmd.clr_wr ? clr_addr_r : idx_r[AW-1:0];
  assign wd1   = cmd.clr_wr ? '0 : q1_r + d1_r;
  assign wd2   = cmd.clr_wr ? '0 : q2_r + d2_r;

  always_ff @(posedge clk) begin
    if (we) begin
      b1_mem[waddr] <= wd1;
      b2_mem[waddr] <= wd2;
    end
    if (cmd.mem_rd) begin
      q1_r <= b1_mem[idx_r[AW-1:0]];
      q2_r <= b2_mem[idx_r[AW-1:0]];
    end
  end

  // Clearing sweep address
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) clr_addr_r <= '0;
    else if (cmd.clr_wr)  clr_addr_r <= clr_addr_r + 1'b1;
  end

  // Request capture, walk index and sums
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      err_r <= (in_left_index == '0) || (in_left_index > in_right_index) ||
               (in_right_index > count);
      l_r   <= IW'(in_left_index);
      r_r   <= IW'(in_right_index);
      d_r   <= in_add_value;
      acc_r <= '0;
    end
    if (cmd.set_pt) begin
      idx_r <= pt;
      w_r   <= pt + 1'b1;
      neg_r <= pt_neg;
      d1_r  <= pt_neg ? (~d_ext + 1'b1) : d_ext;
      d2_r  <= pt_neg ? (~dp_ext + 1'b1) : dp_ext;
      s1_r  <= '0;
      s2_r  <= '0;
    end else if (cmd.upd_wr) begin
      idx_r <= idx_r + lowbit;
    end else if (cmd.qry_acc) begin
      idx_r <= idx_r - lowbit;
      s1_r  <= s1_r + q1_r;
      s2_r  <= s2_r + q2_r;
    end
    if (cmd.mul) prod_r <= SUM_W'(s1_r * SUM_W'(w_r));
    if (cmd.acc) acc_r  <= neg_r ? (acc_r - diff) : (acc_r + diff);
  end

  assign sts.err      = err_r;
  assign sts.is_query = (cmd_r == CMD_QUERY);
  assign sts.up_done  = (idx_r == '0) || (32'(idx_r) > 32'(count));
  assign sts.dn_done  = (idx_r == '0);
  assign sts.clr_last = &clr_addr_r;

  assign res_err = err_r;
  assign res_sum = (err_r || cmd_r == CMD_ADD) ? '0 : $signed(acc_r);

endmodule

// ===== src/segment_tree_range_add_sum_core.sv =====
// Top level: register port, request/result handshakes, controller and datapath.
//
// Channel  Direction  Handshake            Payload
// in_      request    in_valid/in_ready    in_command, in_left_index, in_right_index,
//                                          in_add_value
// out_     result     out_valid/out_ready  out_range_sum, out_range_error
// cfg_     register   APB write/read       element_count at byte address 0
//
// With L = floor(log2(n)), n the element count, an add makes two update walks and a
// query two prefix walks over the binary indexed tables, each a read and a write or
// accumulate per node over at most L + 1 nodes; a query also multiplies and adds up
// per walk. A rejected range skips the walks. After reset and after every count write
// a clearing sweep over all 2^clog2(MAX_ELEMENTS+1) table entries (2048 by default)
// runs with in_ready low. A finished result waits in an output register while the
// next request is taken.
`timescale 1ns / 1ps
module segment_tree_range_add_sum_core
  import segtr_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_command,
  input  logic [CNT_W-1:0]        in_left_index,
  input  logic [CNT_W-1:0]        in_right_index,
  input  logic signed [VAL_W-1:0] in_add_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SUM_W-1:0] out_range_sum,
  output logic                    out_range_error,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [ADDR_W-1:0]       cfg_paddr,
  input  logic [31:0]             cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  logic             count_wr;
  logic [CNT_W-1:0] count_r, wr_val;
  logic             in_fire, out_load, out_valid_r, out_err_r;
  logic [SUM_W-1:0] out_sum_r;
  logic signed [SUM_W-1:0] res_sum;
  logic             res_err;
  segtr_cmd_t       cmd;
  segtr_sts_t       sts;

  // Register port
  assign cfg_pready = 1'b1;
  assign count_wr   = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[ADDR_W-1] == REG_ELEMENT_COUNT[ADDR_W-1]);
  assign wr_val     = cfg_pwdata[CNT_W-1:0];
  assign cfg_prdata = 32'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_W'(MAX_ELEMENTS);
    end else if (count_wr) begin
      count_r <= (32'(wr_val) > 32'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS) : wr_val;
    end
  end

  assign in_fire = in_valid && in_ready;

  segtr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .cfg_wr   (count_wr),
    .out_busy (out_valid_r && !out_ready),
    .sts      (sts),
    .in_ready (in_ready),
    .out_load (out_load),
    .cmd      (cmd)
  );

  segtr_dpath #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_wr         (count_wr),
    .count          (count_r),
    .in_command     (in_command),
    .in_left_index  (in_left_index),
    .in_right_index (in_right_index),
    .in_add_value   (in_add_value),
    .sts            (sts),
    .res_sum        (res_sum),
    .res_err        (res_err)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_sum_r <= res_sum;
      out_err_r <= res_err;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_range_sum   = $signed(out_sum_r);
  assign out_range_error = out_err_r;

  // A rejected range never reports a sum
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> out_range_sum == '0)
    else $error("rejected range carries a nonzero sum");

  // A count write starts the clearing sweep
  a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
    count_wr |=> !in_ready)
    else $error("request taken during clearing sweep");

  // One request in flight at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("second request taken while busy");

endmodule

// ===== dv/segment_tree_range_add_sum_core_test.sv =====
// Self-checking testbench for the range-add / range-sum core.
`timescale 1ns / 1ps
module segment_tree_range_add_sum_core_test;
  import segtr_pkg::*;

  localparam int MAX_ELEM = 1024;
  localparam int WATCH_LIMIT = 40000;
  localparam logic [ADDR_W-1:0] REG_UNUSED = 3'd4;

  typedef struct {
    logic signed [SUM_W-1:0] range_sum;
    logic                    range_error;
  } range_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_command = CMD_ADD;
  logic [CNT_W-1:0]        in_left_index = '0;
  logic [CNT_W-1:0]        in_right_index = '0;
  logic signed [VAL_W-1:0] in_add_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [SUM_W-1:0] out_range_sum;
  logic                    out_range_error;
  logic                    cfg_psel = 1'b0;
  logic                    cfg_penable = 1'b0;
  logic                    cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]       cfg_paddr = '0;
  logic [31:0]             cfg_pwdata = '0;
  logic [31:0]             cfg_prdata;
  logic                    cfg_pready;

  // Shadow of the array contents and the element count
  logic [SUM_W-1:0] shadow_elems [1:MAX_ELEM];
  int unsigned      shadow_count;
  range_result_t    pending_results [$];

  int  fail_count = 0;
  int  idle_cycles = 0;
  bit  gaps_on = 1'b1;
  int  rx_hold = 0;
  int  rx_burst = 0;

  segment_tree_range_add_sum_core u_top (.*);

  always #6 clk = ~clk;

  // Clear the shadow array
  function automatic void shadow_clear();
    for (int i = 1; i <= MAX_ELEM; i++) shadow_elems[i] = '0;
  endfunction

  // Work out the result of one accepted request and update the shadow
  function automatic range_result_t apply_request(logic cmd, int unsigned lft,
                                                  int unsigned rgt, logic signed [31:0] amt);
    range_result_t r;
    logic [SUM_W-1:0] acc;
    r.range_sum = '0;
    r.range_error = 1'b0;
    acc = '0;
    if (lft < 1 || lft > rgt || rgt > shadow_count) begin
      r.range_error = 1'b1;
    end else if (cmd == CMD_ADD) begin
      for (int i = lft; i <= rgt; i++) shadow_elems[i] += SUM_W'(amt);
    end else begin
      for (int i = lft; i <= rgt; i++) acc += shadow_elems[i];
      r.range_sum = acc;
    end
    return r;
  endfunction

  // Watchdog: cycles without any accepted request or result
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCH_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Result side: drive out_ready with holds and stall bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready = 1'b0;
    end else if (rx_hold > 0) begin
      out_ready = 1'b0;
      rx_hold--;
    end else if (rx_burst > 0) begin
      out_ready = 1'b0;
      rx_burst--;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      out_ready = 1'b0;
      rx_burst = $urandom_range(0, 7);
    end else begin
      out_ready = 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    range_result_t exp_r;
    if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result sum=%0d err=%0b", $time, out_range_sum,
                 out_range_error);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_range_sum !== exp_r.range_sum) begin
          $display("%0t: range_sum expected %0d actual %0d", $time, exp_r.range_sum,
                   out_range_sum);
          fail_count++;
        end
        if (out_range_error !== exp_r.range_error) begin
          $display("%0t: range_error expected %0b actual %0b", $time, exp_r.range_error,
                   out_range_error);
          fail_count++;
        end
      end
    end
  end

  // Send one request; called at a falling edge, returns at a falling edge
  task automatic send_request(logic cmd, int unsigned lft, int unsigned rgt,
                              logic signed [31:0] amt);
    int gap;
    in_valid = 1'b1;
    in_command = cmd;
    in_left_index = CNT_W'(lft);
    in_right_index = CNT_W'(rgt);
    in_add_value = amt;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_request(cmd, in_left_index, in_right_index, amt));
    @(negedge clk);
    in_valid = 1'b0;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
    end
  endtask

  // Wait until all results are in, then let the core settle
  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // Register write over the APB port, only while idle
  task automatic write_reg(logic [ADDR_W-1:0] addr, logic [31:0] data);
    int unsigned v;
    wait_drained();
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_paddr = addr;
    cfg_pwdata = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    if (addr == REG_ELEMENT_COUNT) begin
      v = data & 32'h7FF;
      shadow_count = (v > MAX_ELEM) ? MAX_ELEM : v;
      shadow_clear();
    end
  endtask

  // One random request against the current count
  task automatic random_request();
    int unsigned n, lft, rgt, span;
    logic signed [31:0] amt;
    logic cmd;
    n = (shadow_count == 0) ? 1 : shadow_count;
    cmd = 1'($urandom_range(0, 1));
    amt = $urandom();
    if ($urandom_range(0, 9) == 0) amt = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
    if ($urandom_range(0, 9) == 0) begin
      // malformed range
      case ($urandom_range(0, 2))
        0: begin lft = 0; rgt = $urandom_range(0, 2047); end
        1: begin lft = $urandom_range(2, 2047); rgt = $urandom_range(1, lft - 1); end
        default: begin lft = $urandom_range(1, 2047); rgt = $urandom_range(n + 1, 2047); end
      endcase
    end else begin
      lft = $urandom_range(1, n);
      span = $urandom_range(0, 1) ? (n - lft) : $urandom_range(0, (n - lft < 8) ? n - lft : 8);
      rgt = lft + $urandom_range(0, span);
    end
    send_request(cmd, lft, rgt, amt);
  endtask

  // Field extremes, both commands and every kind of rejected range
  task automatic test_directed();
    send_request(CMD_QUERY, 1, 1024, 0);
    send_request(CMD_ADD, 1, 1, 32'sh7FFFFFFF);
    send_request(CMD_ADD, 1024, 1024, 32'sh80000000);
    send_request(CMD_ADD, 1, 1024, 32'sh7FFFFFFF);
    send_request(CMD_ADD, 1, 1024, 32'sh7FFFFFFF);
    send_request(CMD_ADD, 512, 513, -1);
    send_request(CMD_QUERY, 1, 1024, 0);
    send_request(CMD_QUERY, 1, 1, 0);
    send_request(CMD_QUERY, 1024, 1024, 0);
    send_request(CMD_QUERY, 500, 600, 0);
    send_request(CMD_ADD, 0, 5, 7);
    send_request(CMD_QUERY, 0, 0, 0);
    send_request(CMD_ADD, 9, 8, 7);
    send_request(CMD_QUERY, 1025, 1025, 0);
    send_request(CMD_ADD, 2047, 2047, -5);
    send_request(CMD_QUERY, 1, 2047, 0);
    send_request(CMD_QUERY, 1, 1024, 0);
  endtask

  // Count settings: minimum, zero, saturation, unused address
  task automatic test_config();
    write_reg(REG_ELEMENT_COUNT, 1);
    send_request(CMD_ADD, 1, 1, 32'sh80000000);
    send_request(CMD_QUERY, 1, 1, 0);
    send_request(CMD_QUERY, 1, 2, 0);
    write_reg(REG_ELEMENT_COUNT, 0);
    send_request(CMD_ADD, 1, 1, 3);
    send_request(CMD_QUERY, 1, 1, 0);
    write_reg(REG_ELEMENT_COUNT, 32'hFFFF_FFFF);
    send_request(CMD_QUERY, 1, 1024, 0);
    send_request(CMD_ADD, 1000, 1024, 11);
    write_reg(REG_UNUSED, 3);
    send_request(CMD_QUERY, 1, 1024, 0);
    send_request(CMD_QUERY, 1025, 1025, 0);
  endtask

  // Random traffic over several counts
  task automatic test_random();
    int unsigned counts [5] = '{1024, 7, 2, 100, 1023};
    foreach (counts[k]) begin
      write_reg(REG_ELEMENT_COUNT, counts[k]);
      repeat (85) random_request();
    end
  endtask

  // Long receiver hold so the core fills and stalls requests
  task automatic test_backpressure();
    rx_hold = 400;
    repeat (20) random_request();
  endtask

  // Sender pauses until every result is back
  task automatic test_drain_pause();
    repeat (10) random_request();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) random_request();
  endtask

  // Last stretch with no idling on either side
  task automatic test_full_rate();
    gaps_on = 1'b0;
    repeat (60) random_request();
  endtask

  initial begin
    shadow_clear();
    shadow_count = MAX_ELEM;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_config();
    test_random();
    test_backpressure();
    test_drain_pause();
    test_full_rate();
    wait_drained();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/segtr_pkg.sv
src/segtr_ctrl.sv
src/segtr_dpath.sv
src/segment_tree_range_add_sum_core.sv
dv/segment_tree_range_add_sum_core_test.sv
